/* sv/gch_pkg.sv */
// Package for grid_cell_hash_open: sizes, mixer constants, payload types.
// No dependencies.
package gch_pkg;
  localparam int TableDepth = 1024;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = 11;
  localparam logic [63:0] Mul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] Mul2 = 64'h94d049bb133111eb;
  localparam logic [CntW-1:0] ResetCount = 11'd1024;

  typedef struct packed {
    logic [31:0] cell_x;
    logic [31:0] cell_y;
  } cell_t;

  typedef struct packed {
    logic [9:0] slot_index;
    logic       created;
    logic       table_full;
  } result_t;

  // 64x64 multiplier request/response
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;
endpackage

/* sv/gch_if.sv */
// Valid/ready stream interface carrying a gch_pkg::cell_t payload.
// Depends on gch_pkg for payload types.
interface gch_cell_if (input logic clk);
  logic valid;
  logic ready;
  gch_pkg::cell_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/gch_res_if.sv */
// Valid/ready stream interface for lookup results.
// Depends on gch_pkg.
interface gch_res_if (input logic clk);
  logic valid;
  logic ready;
  gch_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/gch_mul.sv */
// Iterative 64x64 low-half multiplier, one 32x16 partial product a cycle.
// Depends on gch_pkg.
module gch_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  gch_pkg::mul_req_t req,
  output gch_pkg::mul_rsp_t rsp
);
  logic [63:0] a_r, b_r, acc_r;
  logic [2:0]  step_r;
  logic        busy_r, done_r;
  logic [47:0] pp;
  logic [63:0] pp_sh;

  // step k: a[32*(k/4) +: 32] * b[16*(k%4) +: 16], shifted
  always_comb begin
    pp = a_r[{step_r[2], 5'd0} +: 32] * b_r[{step_r[1:0], 4'd0} +: 16];
    pp_sh = {16'd0, pp} << ({step_r[2], 5'd0} + {step_r[1:0], 4'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // upper-a times upper-b lands above bit 63: only steps 0..5 matter
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p = acc_r;
endmodule

/* sv/grid_cell_hash_open.sv */
// grid_cell_hash_open: add-or-get of a 2D cell in a linear-probed table.
// Flow: two multiplies through gch_mul, a restoring modulo by slot_count-1 over
// the 64-bit hash, then probe and output when the home slot decides; each
// further probe passes through S_RD and S_CHK again.
// One transaction at a time: a new one is taken only in S_IDLE.
// Reset: sets slot_count to 1024, then a pass over all 1024 slots clears the used map.
module grid_cell_hash_open (
  input  logic        clk,
  input  logic        rst_n,
  gch_cell_if.sink    in_ch,
  gch_res_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_W1 = 4'd2, S_M2 = 4'd3,
                         S_W2 = 4'd4, S_DIV = 4'd5, S_RD = 4'd6, S_CHK = 4'd7,
                         S_OUT = 4'd8, S_CLR = 4'd9;
  localparam int IW = gch_pkg::IdxW;

  logic [3:0] state_r;
  logic [gch_pkg::CntW-1:0] count_r;
  logic [63:0] h_r;
  logic [IW:0] rem_r, n_r;
  logic [6:0] bit_r;
  logic [IW-1:0] probe_r;
  logic [IW-1:0] clr_r;
  logic [IW:0] steps_r;
  gch_pkg::cell_t key_r;
  gch_pkg::result_t res_r;
  gch_pkg::result_t pend_r;
  logic out_v_r;
  logic        used_mem [gch_pkg::TableDepth];
  logic [31:0] mem_x [gch_pkg::TableDepth];
  logic [31:0] mem_y [gch_pkg::TableDepth];
  logic [31:0] rd_x_r, rd_y_r;
  logic        rd_used_r;
  gch_pkg::mul_req_t mreq;
  gch_pkg::mul_rsp_t mrsp;
  logic [IW+1:0] rem_sh;
  logic [IW:0] nm1;
  logic wr_en;

  gch_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {21'd0, count_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= gch_pkg::ResetCount;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0)
      count_r <= cfg_pwdata[gch_pkg::CntW-1:0];
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data = res_r;
  assign nm1 = n_r - 1'b1;
  assign rem_sh = {rem_r, h_r[63]};

  always_comb begin
    mreq.start = 1'b0;
    mreq.a = h_r;
    mreq.b = gch_pkg::Mul1;
    if (state_r == S_M1) mreq.start = 1'b1;
    if (state_r == S_M2) begin
      mreq.start = 1'b1;
      mreq.b = gch_pkg::Mul2;
    end
  end

  assign wr_en = (state_r == S_CHK) && !rd_used_r && !steps_r[IW] && (steps_r != nm1);

  // coordinate memories and used map, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[probe_r] <= key_r.cell_x;
      mem_y[probe_r] <= key_r.cell_y;
    end
    if (state_r == S_CLR) used_mem[clr_r] <= 1'b0;
    else if (wr_en) used_mem[probe_r] <= 1'b1;
    rd_x_r <= mem_x[probe_r];
    rd_y_r <= mem_y[probe_r];
    rd_used_r <= used_mem[probe_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      // result register, loaded only once the previous transaction has left
      if (state_r == S_OUT && (!out_v_r || out_ch.ready)) begin
        out_v_r <= 1'b1;
        res_r <= pend_r;
      end else if (out_v_r && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IW'(gch_pkg::TableDepth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          key_r <= in_ch.data;
          h_r <= {in_ch.data.cell_x, in_ch.data.cell_y} ^
                 ({in_ch.data.cell_x, in_ch.data.cell_y} >> 30);
          if (count_r < 11'd2) n_r <= 11'd2;
          else if (count_r > 11'(gch_pkg::TableDepth)) n_r <= 11'(gch_pkg::TableDepth);
          else n_r <= count_r;
          state_r <= S_M1;
        end
        S_M1: state_r <= S_W1;
        S_W1: if (mrsp.done) begin
          h_r <= mrsp.p ^ (mrsp.p >> 27);
          state_r <= S_M2;
        end
        S_M2: state_r <= S_W2;
        S_W2: if (mrsp.done) begin
          h_r <= mrsp.p ^ (mrsp.p >> 31);
          rem_r <= '0;
          bit_r <= '0;
          state_r <= S_DIV;
        end
        // restoring remainder, one bit a cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, nm1}) rem_r <= (IW+1)'(rem_sh - {1'b0, nm1});
          else rem_r <= rem_sh[IW:0];
          h_r <= {h_r[62:0], 1'b0};
          bit_r <= bit_r + 7'd1;
          if (bit_r == 7'd63) state_r <= S_RD;
          steps_r <= '0;
        end
        S_RD: begin
          if (bit_r[6]) begin
            probe_r <= IW'(rem_r + 1'b1);
            bit_r <= '0;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (steps_r == nm1) begin
            pend_r <= '{slot_index: '0, created: 1'b0, table_full: 1'b1};
            state_r <= S_OUT;
          end else if (!rd_used_r) begin
            pend_r <= '{slot_index: probe_r, created: 1'b1, table_full: 1'b0};
            state_r <= S_OUT;
          end else if (rd_x_r == key_r.cell_x && rd_y_r == key_r.cell_y) begin
            pend_r <= '{slot_index: probe_r, created: 1'b0, table_full: 1'b0};
            state_r <= S_OUT;
          end else begin
            steps_r <= steps_r + 1'b1;
            if ({1'b0, probe_r} + 1'b1 >= n_r) probe_r <= IW'(1);
            else probe_r <= probe_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_OUT: if (!out_v_r || out_ch.ready) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
